// ===== hdl/cnsr_pkg.sv =====
// Shared types, codes and helpers for the calibrated nearest-setpoint ramper.
// Used by the scan cell and the top level; depends on nothing else.

package cnsr_pkg;

   // Fixed field widths of the item and register interfaces.
   localparam int POS_W   = 7;
   localparam int VOLT_W  = 12;
   localparam int TICK_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Reset values and the starting error of a nearest-voltage search.
   localparam logic [POS_W-1:0]  RESET_DEFAULT_POS = 7'd64;
   localparam logic [VOLT_W-1:0] RESET_TOLERANCE   = 12'd5;
   localparam logic [TICK_W-1:0] RESET_SPACING     = 16'd1;
   localparam logic [VOLT_W-1:0] SCAN_START_ERR    = 12'd1000;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_POS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRED    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACING     = 3'd4;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_STORE      = 2'd0,
      OP_FINISH     = 2'd1,
      OP_SET_TARGET = 2'd2,
      OP_TICK       = 2'd3
   } cnsr_op_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } cnsr_state_type;

   // Input item.
   typedef struct packed {
      cnsr_op_type        op;
      logic [POS_W-1:0]   table_index;
      logic [VOLT_W-1:0]  volts;
   } cnsr_req_type;

   // Result item.
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             fault;
      logic             reached;
   } cnsr_rsp_type;

   // Table write broadcast to every cell.
   typedef struct packed {
      logic               en;
      logic [POS_W-1:0]   idx;
      logic [VOLT_W-1:0]  volts;
   } cnsr_wr_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic [VOLT_W-1:0] target;
      logic [VOLT_W-1:0] best_err;
      logic [POS_W-1:0]  best_idx;
   } cnsr_token_type;

   // Raise to the lower bound first, then lower to the upper bound.
   function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
                                                  input logic [POS_W-1:0] lo,
                                                  input logic [POS_W-1:0] hi);
      logic [POS_W-1:0] r;
      r = p;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

endpackage

// ===== hdl/cnsr_cell.sv =====
// One cell of the calibration table: holds the voltage of one position and
// updates the passing search token. Depends on cnsr_pkg.

module cnsr_cell
   import cnsr_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int VW         = 12
) (
   input  logic           clock,
   input  logic           reset,
   input  cnsr_wr_type    wr,
   input  logic           tok_valid_in,
   input  cnsr_token_type tok_in,
   output logic           tok_valid_out,
   output cnsr_token_type tok_out
);

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(CELL_INDEX);

   logic [VW-1:0]     entry_ff;
   logic              tok_valid_ff;
   cnsr_token_type    tok_ff;
   cnsr_token_type    tok_in_upd;
   logic [VOLT_W-1:0] entry_ext;
   logic [VOLT_W-1:0] err;

   // Distance between this entry and the target; take it only if strictly closer.
   always_comb begin
      entry_ext  = VOLT_W'(entry_ff);
      err        = (entry_ext > tok_in.target) ? entry_ext - tok_in.target
                                               : tok_in.target - entry_ext;
      tok_in_upd = tok_in;
      if (err < tok_in.best_err) begin
         tok_in_upd.best_err = err;
         tok_in_upd.best_idx = MY_IDX;
      end
   end

   // Table entry, written when a store item addresses this position.
   always_ff @(posedge clock) begin
      if (wr.en && (wr.idx == MY_IDX)) begin
         entry_ff <= wr.volts[VW-1:0];
      end
   end

   // Token stage toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_upd;
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_out       = tok_ff;

endmodule

// ===== hdl/calibrated_nearest_setpoint_ramper.sv =====
// Calibrated nearest-setpoint ramper. Store, finish and tick items are handled
// in the cycle they are accepted; store and finish items always register a
// result, a tick item only when it steps the ramp. Another item is taken at
// once unless a result is still held for rsp_ready. A set-target item sends a
// search token down a row of min(TABLE_DEPTH, 128) table cells, one cell per
// cycle; no item is accepted until the search ends. The table needs no
// clearing after reset, but every scanned entry must be stored before the
// first set-target item. Configuration writes are taken in any cycle.

module calibrated_nearest_setpoint_ramper
   import cnsr_pkg::*;
#(
   parameter int TABLE_DEPTH = 128,
   parameter int VOLT_BITS   = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cnsr_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cnsr_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int MAX_POS_I = (TABLE_DEPTH - 1 < 127) ? TABLE_DEPTH - 1 : 127;
   localparam int NUM_CELLS = MAX_POS_I + 1;
   localparam int VW        = (VOLT_BITS < VOLT_W) ? VOLT_BITS : VOLT_W;
   localparam logic [POS_W-1:0]  MAX_POS   = POS_W'(MAX_POS_I);
   localparam logic [VOLT_W-1:0] VOLT_MASK = VOLT_W'((1 << VW) - 1);

   // Configuration registers.
   logic [POS_W-1:0]  min_pos_ff;
   logic [POS_W-1:0]  default_pos_ff;
   logic [VOLT_W-1:0] required_ff;
   logic [VOLT_W-1:0] tolerance_ff;
   logic [TICK_W-1:0] spacing_ff;

   // Control state.
   cnsr_state_type    state_ff, state_in;
   logic [POS_W-1:0]  cur_pos_ff, cur_pos_in;
   logic [POS_W-1:0]  tgt_pos_ff, tgt_pos_in;
   logic              ramp_ff, ramp_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [VW-1:0]     max_ff, max_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cnsr_rsp_type      rsp_data_ff, rsp_data_in;

   // Cell row.
   logic [NUM_CELLS:0] tok_valid;
   cnsr_token_type     tok [NUM_CELLS+1];
   cnsr_wr_type        wr;

   logic              req_accept;
   logic [VOLT_W-1:0] volts_m;
   logic [TICK_W-1:0] tick_next;
   logic              rsp_free;
   logic              load;
   logic [POS_W-1:0]  pos_v;
   logic [POS_W-1:0]  tgt_v;
   logic              fault_v;

   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && rsp_free;
   assign req_accept = req_valid && req_ready;
   assign volts_m    = req_data.volts & VOLT_MASK;
   assign tick_next  = tick_ff + TICK_W'(1);

   // Table write and search token entering the first cell.
   assign wr.en           = req_accept && (req_data.op == OP_STORE);
   assign wr.idx          = req_data.table_index;
   assign wr.volts        = volts_m;
   assign tok_valid[0]    = req_accept && (req_data.op == OP_SET_TARGET);
   assign tok[0].target   = volts_m;
   assign tok[0].best_err = SCAN_START_ERR;
   assign tok[0].best_idx = '0;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      cnsr_cell #(
         .CELL_INDEX (g),
         .VW         (VW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .wr            (wr),
         .tok_valid_in  (tok_valid[g]),
         .tok_in        (tok[g]),
         .tok_valid_out (tok_valid[g+1]),
         .tok_out       (tok[g+1])
      );
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pos_ff     <= '0;
         default_pos_ff <= RESET_DEFAULT_POS;
         required_ff    <= '0;
         tolerance_ff   <= RESET_TOLERANCE;
         spacing_ff     <= RESET_SPACING;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_POS:     min_pos_ff     <= csr_data[POS_W-1:0];
            CSR_DEFAULT_POS: default_pos_ff <= csr_data[POS_W-1:0];
            CSR_REQUIRED:    required_ff    <= csr_data[VOLT_W-1:0];
            CSR_TOLERANCE:   tolerance_ff   <= csr_data[VOLT_W-1:0];
            CSR_SPACING:     spacing_ff     <= csr_data[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: item decode, search completion and result register load.
   always_comb begin
      state_in    = state_ff;
      cur_pos_in  = cur_pos_ff;
      tgt_pos_in  = tgt_pos_ff;
      ramp_in     = ramp_ff;
      tick_in     = tick_ff;
      max_in      = max_ff;
      load        = 1'b0;
      fault_v     = 1'b0;
      pos_v       = cur_pos_ff;
      tgt_v       = tgt_pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.op)
                  OP_STORE: begin
                     // An index past the table moves the position but keeps the maximum.
                     if ((int'(req_data.table_index) < TABLE_DEPTH) &&
                         (VOLT_W'(max_ff) < volts_m)) begin
                        max_in = volts_m[VW-1:0];
                     end
                     pos_v   = clamp_pos(req_data.table_index, min_pos_ff, MAX_POS);
                     ramp_in = 1'b0;
                     load    = 1'b1;
                  end
                  OP_FINISH: begin
                     ramp_in = 1'b0;
                     load    = 1'b1;
                     if (VOLT_W'(max_ff) < required_ff) begin
                        fault_v = 1'b1;
                     end else begin
                        pos_v = clamp_pos(default_pos_ff, min_pos_ff, MAX_POS);
                     end
                  end
                  OP_SET_TARGET: begin
                     state_in = ST_SCAN;
                  end
                  OP_TICK: begin
                     if (ramp_ff) begin
                        if (tick_next < spacing_ff) begin
                           tick_in = tick_next;
                        end else begin
                           tick_in = '0;
                           load    = 1'b1;
                           if (cur_pos_ff < tgt_pos_ff) begin
                              pos_v = cur_pos_ff + POS_W'(1);
                           end else if (cur_pos_ff > tgt_pos_ff) begin
                              pos_v = cur_pos_ff - POS_W'(1);
                           end
                           ramp_in = (pos_v != tgt_pos_ff);
                        end
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // The token leaving the last cell carries the nearest entry.
            if (tok_valid[NUM_CELLS]) begin
               state_in = ST_IDLE;
               load     = 1'b1;
               if (tok[NUM_CELLS].best_err > tolerance_ff) begin
                  fault_v = 1'b1;
                  ramp_in = 1'b0;
                  pos_v   = clamp_pos(min_pos_ff, min_pos_ff, MAX_POS);
               end else begin
                  tgt_v   = clamp_pos(tok[NUM_CELLS].best_idx, min_pos_ff, MAX_POS);
                  pos_v   = clamp_pos(cur_pos_ff, min_pos_ff, MAX_POS);
                  tick_in = '0;
                  ramp_in = (pos_v != tgt_v);
               end
            end
         end
      endcase

      if (load) begin
         cur_pos_in = pos_v;
         tgt_pos_in = tgt_v;
      end
      rsp_data_in.position = pos_v;
      rsp_data_in.fault    = fault_v;
      rsp_data_in.reached  = (pos_v == tgt_v);
      rsp_valid_in         = load || (rsp_valid_ff && !rsp_ready);
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_pos_ff   <= '0;
         tgt_pos_ff   <= '0;
         ramp_ff      <= 1'b0;
         tick_ff      <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_pos_ff   <= cur_pos_in;
         tgt_pos_ff   <= tgt_pos_in;
         ramp_ff      <= ramp_in;
         tick_ff      <= tick_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Only one search is ever in flight along the cell row.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid) <= 1)
      else $error("more than one search token in the cell row");

   // A token only reaches the end of the row while a search is pending.
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_valid[NUM_CELLS] |-> state_ff == ST_SCAN)
      else $error("search result arrived outside a search");

   // An active ramp always has somewhere to go.
   a_ramp_moves: assert property (@(posedge clock) disable iff (reset)
      ramp_ff |-> cur_pos_ff != tgt_pos_ff)
      else $error("ramp active with position already at target");

   // No item is taken while a search runs.
   a_scan_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !req_ready)
      else $error("item accepted during a search");
`endif

endmodule
